// ===== rtl/core/epb_pkg.sv =====
`default_nettype none
package epb_pkg;
	localparam int PIECE_BITS = 16;
	localparam int COORD_BITS = 32;
	localparam int SIZE_BITS  = COORD_BITS + 2;
	localparam int PROD_BITS  = COORD_BITS + 1 + PIECE_BITS;

	localparam logic [1:0] AXIS_BLOCK = 2'd3;

	localparam logic [2:0] REG_X_MIN = 3'd0;
	localparam logic [2:0] REG_X_MAX = 3'd1;
	localparam logic [2:0] REG_Y_MIN = 3'd2;
	localparam logic [2:0] REG_Y_MAX = 3'd3;
	localparam logic [2:0] REG_Z_MIN = 3'd4;
	localparam logic [2:0] REG_Z_MAX = 3'd5;
	localparam logic [2:0] REG_SLAB  = 3'd6;
	localparam logic [2:0] REG_GHOST = 3'd7;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PICK,
		ST_MUL,
		ST_START,
		ST_DIV,
		ST_CUT,
		ST_GHOST,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic load;
		logic pick;
		logic mul;
		logic div_start;
		logic cut;
		logic ghost;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic done;
		logic no_axis;
		logic div_busy;
	} sts_t;
endpackage
`default_nettype wire

// ===== rtl/core/epb_ctrl.sv =====
`default_nettype none
module epb_ctrl (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          in_fire,
	input  wire          out_free,
	input  epb_pkg::sts_t sts,
	output epb_pkg::cmd_t cmd,
	output logic         busy
);
	epb_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= epb_pkg::ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			epb_pkg::ST_IDLE:  if (in_fire) state_d = epb_pkg::ST_PICK;
			epb_pkg::ST_PICK: begin
				if (sts.done) state_d = epb_pkg::ST_GHOST;
				else if (!sts.no_axis) state_d = epb_pkg::ST_MUL;
			end
			epb_pkg::ST_MUL:   state_d = epb_pkg::ST_START;
			epb_pkg::ST_START: state_d = epb_pkg::ST_DIV;
			epb_pkg::ST_DIV:   if (!sts.div_busy) state_d = epb_pkg::ST_CUT;
			epb_pkg::ST_CUT:   state_d = epb_pkg::ST_PICK;
			epb_pkg::ST_GHOST: state_d = epb_pkg::ST_OUT;
			epb_pkg::ST_OUT:   if (out_free) state_d = epb_pkg::ST_IDLE;
			default:           state_d = epb_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		busy = (state_q != epb_pkg::ST_IDLE);
		unique case (state_q)
			epb_pkg::ST_IDLE:  cmd.load = in_fire;
			epb_pkg::ST_PICK:  cmd.pick = 1'b1;
			epb_pkg::ST_MUL:   cmd.mul = 1'b1;
			// product is registered, divider starts in the next cycle
			epb_pkg::ST_START: cmd.div_start = 1'b1;
			epb_pkg::ST_DIV:   ;
			epb_pkg::ST_CUT:   cmd.cut = 1'b1;
			epb_pkg::ST_GHOST: cmd.ghost = 1'b1;
			epb_pkg::ST_OUT:   cmd.out_load = out_free;
			default:           ;
		endcase
	end
endmodule
`default_nettype wire

// ===== rtl/core/epb_div.sv =====
`default_nettype none
module epb_div (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               start,
	input  wire [epb_pkg::PROD_BITS-1:0]      dividend,
	input  wire [epb_pkg::PIECE_BITS-1:0]     divisor,
	output logic                              busy,
	output logic [epb_pkg::PROD_BITS-1:0]     quotient
);
	localparam int CW = $clog2(epb_pkg::PROD_BITS + 1);
	logic [CW-1:0] cnt_q;
	logic [epb_pkg::PROD_BITS-1:0] quo_q;
	logic [epb_pkg::PIECE_BITS:0] rem_q;
	logic [epb_pkg::PIECE_BITS:0] trial;
	logic [epb_pkg::PIECE_BITS:0] shifted;

	// one quotient bit per cycle, restoring
	assign shifted = {rem_q[epb_pkg::PIECE_BITS-1:0], quo_q[epb_pkg::PROD_BITS-1]};
	assign trial = shifted - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) cnt_q <= '0;
		else if (start) cnt_q <= CW'(epb_pkg::PROD_BITS);
		else if (cnt_q != '0) cnt_q <= cnt_q - 1'b1;
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			if (!trial[epb_pkg::PIECE_BITS]) begin
				rem_q <= trial;
				quo_q <= {quo_q[epb_pkg::PROD_BITS-2:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[epb_pkg::PROD_BITS-2:0], 1'b0};
			end
		end
	end

	assign busy = (cnt_q != '0) || start;
	assign quotient = quo_q;
endmodule
`default_nettype wire

// ===== rtl/core/epb_dp.sv =====
`default_nettype none
module epb_dp (
	input  wire                           clk,
	input  epb_pkg::cmd_t                 cmd,
	input  wire [epb_pkg::PIECE_BITS-1:0] piece_in,
	input  wire [epb_pkg::PIECE_BITS-1:0] total_in,
	input  wire                           mode_in,
	input  wire [31:0]                    whole [6],
	input  wire [1:0]                     slab,
	input  wire [7:0]                     ghost,
	input  wire                           div_busy,
	input  wire [epb_pkg::PROD_BITS-1:0]  div_q,
	output logic [epb_pkg::PROD_BITS-1:0] prod,
	output logic [epb_pkg::PIECE_BITS-1:0] divisor,
	output epb_pkg::sts_t                 sts,
	output logic [31:0]                   res [6],
	output logic                          res_ok
);
	localparam int SB = epb_pkg::SIZE_BITS;
	localparam int CB = epb_pkg::COORD_BITS;

	logic signed [SB-1:0] box_q [6];
	logic signed [SB-1:0] size [3];
	logic [epb_pkg::PIECE_BITS-1:0] piece_q, total_q, half;
	logic points_q, ok_q;
	logic [1:0] axis_q, axis_d;
	logic axis_none;
	logic [CB:0] size_sel_q;
	logic signed [SB-1:0] wbox [6];
	logic signed [SB-1:0] cut;
	logic signed [SB-1:0] g;

	assign half = total_q >> 1;
	assign divisor = total_q;
	assign g = SB'(signed'({1'b0, ghost}));

	for (genvar k = 0; k < 6; k++) begin : g_w
		assign wbox[k] = SB'(signed'(whole[k][CB-1:0]));
	end
	for (genvar a = 0; a < 3; a++) begin : g_sz
		assign size[a] = box_q[2*a+1] - box_q[2*a] + SB'(points_q);
	end

	always_comb begin
		axis_d = 2'd0;
		axis_none = 1'b0;
		if (slab != epb_pkg::AXIS_BLOCK && size[slab] > SB'(1)) axis_d = slab;
		else if (size[2] >= size[1] && size[2] >= size[0] && size[2] >= SB'(2))
			axis_d = 2'd2;
		else if (size[1] >= size[0] && size[1] >= SB'(2)) axis_d = 2'd1;
		else if (size[0] >= SB'(2)) axis_d = 2'd0;
		else axis_none = 1'b1;
	end

	assign sts.done = !ok_q || total_q <= 1;
	assign sts.no_axis = axis_none;
	assign sts.div_busy = div_busy;

	assign cut = box_q[{axis_q, 1'b0}] + SB'(signed'({1'b0, div_q[CB:0]}));

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			for (int k = 0; k < 6; k++) box_q[k] <= wbox[k];
			piece_q <= piece_in;
			total_q <= total_in;
			points_q <= mode_in;
			ok_q <= mode_in || (piece_in < total_in);
		end else if (cmd.pick && !sts.done) begin
			axis_q <= axis_d;
			size_sel_q <= size[axis_d][CB:0];
			if (axis_none) begin
				if (piece_q == '0) total_q <= epb_pkg::PIECE_BITS'(1);
				else ok_q <= 1'b0;
			end
		end else if (cmd.mul) begin
			prod <= epb_pkg::PROD_BITS'(size_sel_q) * epb_pkg::PROD_BITS'(half);
		end else if (cmd.cut) begin
			if (piece_q < half) begin
				box_q[{axis_q, 1'b1}] <= points_q ? cut - SB'(1) : cut;
				total_q <= half;
			end else begin
				box_q[{axis_q, 1'b0}] <= cut;
				total_q <= total_q - half;
				piece_q <= piece_q - half;
			end
		end else if (cmd.ghost) begin
			for (int a = 0; a < 3; a++) begin
				if (!ok_q) begin
					box_q[2*a] <= '0;
					box_q[2*a+1] <= '1;
				end else begin
					box_q[2*a] <= (box_q[2*a] - g < wbox[2*a]) ? wbox[2*a] : box_q[2*a] - g;
					box_q[2*a+1] <= (box_q[2*a+1] + g > wbox[2*a+1]) ?
						wbox[2*a+1] : box_q[2*a+1] + g;
				end
			end
		end
	end

	// wrap to coordinate width then sign extend
	for (genvar k = 0; k < 6; k++) begin : g_res
		assign res[k] = 32'(signed'(box_q[k][CB-1:0]));
	end
	assign res_ok = ok_q;
endmodule
`default_nettype wire

// ===== rtl/core/extent_piece_bisector_core.sv =====
// each item takes up to 16 bisection steps through the serial divider
// (one quotient bit a cycle); when no axis can be split, the controller
// passes through the pick state once more before finishing
// throughput: one item at a time; next accepted once the result is registered
// reset (arst_n low, asynchronous): registers to 0,-1 extents, block axis,
// zero ghost; controller idle, output empty
`default_nettype none
module extent_piece_bisector_core (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        s_axis_tvalid,
	output logic       s_axis_tready,
	input  wire [39:0] s_axis_tdata, // piece_index, piece_total, mode, zero pad
	output logic       m_axis_tvalid,
	input  wire        m_axis_tready,
	output logic [199:0] m_axis_tdata, // out_x_min..out_z_max, nonempty, pad
	input  wire        cfg_we,
	input  wire [2:0]  cfg_index,
	input  wire [31:0] cfg_data
);
	logic [31:0] whole_q [6];
	logic [1:0] slab_q;
	logic [7:0] ghost_q;
	epb_pkg::cmd_t cmd;
	epb_pkg::sts_t sts;
	logic busy, in_fire, out_free, div_busy, res_ok;
	logic [epb_pkg::PROD_BITS-1:0] prod, div_q;
	logic [epb_pkg::PIECE_BITS-1:0] divisor;
	logic [31:0] res [6];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 6; k++) whole_q[k] <= k[0] ? '1 : '0;
			slab_q <= epb_pkg::AXIS_BLOCK;
			ghost_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				epb_pkg::REG_X_MIN: whole_q[0] <= cfg_data;
				epb_pkg::REG_X_MAX: whole_q[1] <= cfg_data;
				epb_pkg::REG_Y_MIN: whole_q[2] <= cfg_data;
				epb_pkg::REG_Y_MAX: whole_q[3] <= cfg_data;
				epb_pkg::REG_Z_MIN: whole_q[4] <= cfg_data;
				epb_pkg::REG_Z_MAX: whole_q[5] <= cfg_data;
				epb_pkg::REG_SLAB:  slab_q <= cfg_data[1:0];
				epb_pkg::REG_GHOST: ghost_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign s_axis_tready = !busy;
	assign in_fire = s_axis_tvalid && s_axis_tready;
	assign out_free = !m_axis_tvalid || m_axis_tready;

	epb_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .out_free(out_free),
		.sts(sts), .cmd(cmd), .busy(busy)
	);

	epb_div u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start), .dividend(prod),
		.divisor(divisor), .busy(div_busy), .quotient(div_q)
	);

	epb_dp u_dp (
		.clk(clk), .cmd(cmd),
		.piece_in(s_axis_tdata[15:0]), .total_in(s_axis_tdata[31:16]),
		.mode_in(s_axis_tdata[32]),
		.whole(whole_q), .slab(slab_q), .ghost(ghost_q),
		.div_busy(div_busy), .div_q(div_q), .prod(prod), .divisor(divisor),
		.sts(sts), .res(res), .res_ok(res_ok)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) m_axis_tvalid <= 1'b0;
		else if (cmd.out_load) m_axis_tvalid <= 1'b1;
		else if (m_axis_tready) m_axis_tvalid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load)
			m_axis_tdata <= {7'd0, res_ok, res[5], res[4], res[3], res[2], res[1], res[0]};
	end
endmodule
`default_nettype wire

// ===== rtl/core/epb_checker.sv =====
`default_nettype none
module epb_checker (
	input wire clk,
	input wire arst_n,
	input wire s_axis_tvalid,
	input wire s_axis_tready,
	input wire m_axis_tvalid,
	input wire m_axis_tready,
	input wire [199:0] m_axis_tdata
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result dropped while stalled");
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("accepted while working");
	a_empty_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tdata[192] |-> m_axis_tdata[31:0] == 32'd0 &&
		m_axis_tdata[63:32] == 32'hffffffff)
		else $error("empty piece has bounds");
	a_no_result_soon: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
		else $error("result too early");
endmodule

bind extent_piece_bisector_core epb_checker u_epb_checker (
	.clk(clk), .arst_n(arst_n), .s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);
`default_nettype wire

// ===== tb/sv/tb_extent_piece_bisector_core.sv =====
`default_nettype none
module tb_extent_piece_bisector_core;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic signed [31:0] b [6];
		logic               nonempty;
	} piece_box_t;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [39:0]  s_axis_tdata; // piece_index[15:0], piece_total[31:16], mode[32], pad
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [199:0] m_axis_tdata; // x_min, x_max, y_min, y_max, z_min, z_max, nonempty, pad
	logic         cfg_we;
	logic [2:0]   cfg_index;
	logic [31:0]  cfg_data;

	// local copy of the register file
	logic signed [31:0] whole [6];
	logic [1:0]         slab_pref;
	logic [7:0]         ghost;

	piece_box_t expected_boxes [$];
	int         mismatches;
	int         results_seen;
	int         items_sent;
	bit         rx_enable;

	extent_piece_bisector_core DUT (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#400ms;
		$display("timeout");
		$display("TEST FAILED");
		$finish;
	end

	function automatic int pick_axis(longint sz [3]);
		if (slab_pref != epb_pkg::AXIS_BLOCK && sz[slab_pref] > 1)
			return slab_pref;
		if (sz[2] >= sz[1] && sz[2] >= sz[0] && sz[2] >= 2)
			return 2;
		if (sz[1] >= sz[0] && sz[1] >= 2)
			return 1;
		if (sz[0] >= 2)
			return 0;
		return -1;
	endfunction

	function automatic piece_box_t bisect_piece(logic [15:0] idx, logic [15:0] tot, logic pts);
		piece_box_t r;
		longint     bx [6];
		longint     sz [3];
		longint     piece, total, half, off, cut;
		bit         ok;
		int         ax;
		piece = idx;
		total = tot;
		ok = !(!pts && piece >= total);
		for (int i = 0; i < 6; i++)
			bx[i] = whole[i];
		while (ok && total > 1) begin
			for (int i = 0; i < 3; i++)
				sz[i] = bx[2*i+1] - bx[2*i] + (pts ? 1 : 0);
			ax = pick_axis(sz);
			if (ax < 0) begin
				if (piece == 0)
					total = 1;
				else
					ok = 0;
			end else begin
				half = total / 2;
				off = (sz[ax] * half) / total;
				cut = bx[2*ax] + off;
				if (piece < half) begin
					bx[2*ax+1] = pts ? cut - 1 : cut;
					total = half;
				end else begin
					bx[2*ax] = cut;
					total -= half;
					piece -= half;
				end
			end
		end
		if (!ok) begin
			for (int i = 0; i < 3; i++) begin
				bx[2*i] = 0;
				bx[2*i+1] = -1;
			end
		end else if (ghost > 0) begin
			for (int i = 0; i < 3; i++) begin
				bx[2*i] -= ghost;
				bx[2*i+1] += ghost;
				if (bx[2*i] < whole[2*i])
					bx[2*i] = whole[2*i];
				if (bx[2*i+1] > whole[2*i+1])
					bx[2*i+1] = whole[2*i+1];
			end
		end
		for (int i = 0; i < 6; i++)
			r.b[i] = bx[i][31:0];
		r.nonempty = ok;
		return r;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		mismatches++;
		$display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
	endtask

	task automatic idle_cycles(int n);
		repeat (n) @(posedge clk);
	endtask

	// result checker with random backpressure
	initial begin
		piece_box_t e;
		m_axis_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready) begin
				results_seen++;
				if (expected_boxes.size() == 0) begin
					report_mismatch("unexpected transaction", 1, 0);
				end else begin
					e = expected_boxes.pop_front();
					for (int i = 0; i < 6; i++)
						if ($signed(m_axis_tdata[32*i +: 32]) !== e.b[i])
							report_mismatch($sformatf("bound %0d", i),
								$signed(m_axis_tdata[32*i +: 32]), e.b[i]);
					if (m_axis_tdata[192] !== e.nonempty)
						report_mismatch("nonempty", m_axis_tdata[192], e.nonempty);
				end
			end
			m_axis_tready <= rx_enable ? ($urandom_range(0, 3) != 0) : 1'b1;
		end
	end

	// tvalid stays high into the next item when there is no gap
	task automatic send_piece(logic [15:0] idx, logic [15:0] tot, logic pts);
		int gap;
		gap = rx_enable ? $urandom_range(0, 3) : 0;
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			idle_cycles(gap);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {7'd0, pts, tot, idx};
		expected_boxes.push_back(bisect_piece(idx, tot, pts));
		do @(posedge clk); while (!s_axis_tready);
		items_sent++;
	endtask

	task automatic drain;
		s_axis_tvalid <= 1'b0;
		while (expected_boxes.size() != 0)
			@(posedge clk);
		idle_cycles(20);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		if (idx <= epb_pkg::REG_Z_MAX)
			whole[idx] = val;
		else if (idx == epb_pkg::REG_SLAB)
			slab_pref = val[1:0];
		else
			ghost = val[7:0];
	endtask

	task automatic set_extent(logic signed [31:0] v [6], logic [1:0] pref, logic [7:0] g);
		drain();
		for (int i = 0; i < 6; i++)
			write_reg(i[2:0], v[i]);
		write_reg(epb_pkg::REG_SLAB, {30'd0, pref});
		write_reg(epb_pkg::REG_GHOST, {24'd0, g});
		cfg_we <= 1'b0;
	endtask

	task automatic test_reset_defaults;
		send_piece(0, 1, 0);
		send_piece(0, 4, 1);
		send_piece(0, 0, 0);
		drain();
	endtask

	task automatic test_directed;
		logic signed [31:0] v [6];
		v = '{0, 99, -50, 49, 10, 10};
		set_extent(v, epb_pkg::AXIS_BLOCK, 0);
		send_piece(0, 0, 0);            // zero total, cell mode: empty
		send_piece(5, 5, 0);            // index past end, cell mode
		send_piece(7, 0, 1);            // zero total, point mode: whole
		send_piece(9, 4, 1);            // past end, point mode
		send_piece(0, 65535, 0);
		send_piece(65534, 65535, 0);
		send_piece(65535, 65535, 1);
		send_piece(3, 8, 0);
		send_piece(3, 8, 1);
		v = '{32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff,
			32'sh8000_0000, 32'sh7fff_ffff};
		set_extent(v, 2'd0, 8'd255);
		send_piece(0, 2, 1);
		send_piece(1, 3, 0);
		send_piece(65535, 65535, 1);
		send_piece(32768, 65535, 0);
		v = '{0, 0, 0, 0, 0, 0};        // nothing splittable
		set_extent(v, 2'd1, 8'd3);
		send_piece(0, 5, 1);
		send_piece(1, 5, 1);
		send_piece(0, 5, 0);
		v = '{5, 2, 0, 1, 7, 3};        // inverted axes
		set_extent(v, 2'd2, 8'd1);
		send_piece(0, 3, 0);
		send_piece(1, 3, 1);
		send_piece(2, 3, 0);
		v = '{32'sh8000_0000, 32'sh8000_0001, 0, 0, 0, 0};  // cut-1 wraps below min
		set_extent(v, 2'd0, 8'd0);
		send_piece(0, 2, 1);
		send_piece(0, 3, 1);
		drain();
	endtask

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return $urandom_range(0, 20) - 10;
			default: return $urandom_range(0, 2000) - 1000;
		endcase
	endfunction

	task automatic test_random;
		logic signed [31:0] v [6];
		logic [15:0] tot, idx;
		for (int phase = 0; phase < 20; phase++) begin
			for (int i = 0; i < 6; i += 2) begin
				v[i] = rand_coord();
				v[i+1] = ($urandom_range(0, 7) == 0) ? rand_coord()
					: v[i] + $urandom_range(0, 300);
			end
			set_extent(v, 2'($urandom_range(0, 3)),
				8'(($urandom_range(0, 3) == 0) ? $urandom : 0));
			for (int k = 0; k < 50; k++) begin
				// mostly small totals keep the run short
				tot = 16'(($urandom_range(0, 15) == 0) ? $urandom : $urandom_range(0, 40));
				idx = 16'(($urandom_range(0, 15) == 0) ? $urandom
					: $urandom_range(0, tot + 1));
				send_piece(idx, tot, 1'($urandom_range(0, 1)));
			end
		end
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		rx_enable = 1'b0;
		mismatches = 0;
		results_seen = 0;
		items_sent = 0;
		whole = '{0, -1, 0, -1, 0, -1};
		slab_pref = epb_pkg::AXIS_BLOCK;
		ghost = 0;
		idle_cycles(5);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		rx_enable = 1'b1;
		test_directed();
		test_random();
		$display("covered %0d pieces and %0d results over directed and random extents",
			items_sent, results_seen);
		if (mismatches == 0 && expected_boxes.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end
endmodule
`default_nettype wire
